// File: rtl/rsc_pkg.sv
// Shared types and constants of the RPN stack calculator.
// No dependencies; every other file of the block but rsc_ram refers to it by scoped names.
`default_nettype none

package rsc_pkg;

	// Fixed widths of the token and result fields.
	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int STS_W  = 3;

	// Token actions.
	localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SUB   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MUL   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DIV   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PRINT = 3'd5;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd6;

	// Result status codes.
	localparam logic [STS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STS_W-1:0] ST_UNDERFLOW = 3'd1;
	localparam logic [STS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STS_W-1:0] ST_DIVZERO   = 3'd3;
	localparam logic [STS_W-1:0] ST_SAT       = 3'd4;

	// The divider produces one quotient bit per step over a 33-bit quotient.
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic addsub;
		logic mul_start;
		logic mul_fin;
		logic div_start;
		logic div_step;
		logic div_fin;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             op_go;
		logic [ACT_W-1:0] op;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/rsc_token_if.sv
// Input channel of the RPN stack calculator: one token per word.
// Depends on rsc_pkg for the field widths.
`default_nettype none

interface rsc_token_if;
	logic                             valid;
	logic                             ready;
	logic [rsc_pkg::ACT_W-1:0]        action;
	logic signed [rsc_pkg::DATA_W-1:0] push_value;

	modport source (output valid, action, push_value, input ready);
	modport sink (input valid, action, push_value, output ready);
endinterface

`default_nettype wire

// File: rtl/rsc_result_if.sv
// Output channel of the RPN stack calculator: one result word per token.
// Depends on rsc_pkg for the field widths.
`default_nettype none

interface rsc_result_if #(
	parameter int STACK_DEPTH = 64
);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic                              valid;
	logic                              ready;
	logic signed [rsc_pkg::DATA_W-1:0] top_value;
	logic                              top_valid;
	logic [rsc_pkg::STS_W-1:0]         status;
	logic [CNT_W-1:0]                  entry_count;
	logic                              print_strobe;

	modport source (output valid, top_value, top_valid, status, entry_count, print_strobe,
		input ready);
	modport sink (input valid, top_value, top_valid, status, entry_count, print_strobe,
		output ready);
endinterface

`default_nettype wire

// File: rtl/rsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/rsc_ctrl.sv
// Controller of the RPN stack calculator: sequences one token through the datapath.
// Depends on rsc_pkg for the command and status types.
`default_nettype none

module rsc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire rsc_pkg::dp_sts_t sts,
	output rsc_pkg::dp_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DFIN = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]                    state_q;
	logic [2:0]                    state_nx;
	logic [rsc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The output register can take a new word when empty or being emptied now.
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.op_go) begin
						cmd.rd_en = 1'b1;
						state_nx  = S_RD;
					end else begin
						state_nx = S_FIN;
					end
				end
			end
			S_RD: begin
				case (sts.op)
					rsc_pkg::ACT_MUL: begin
						cmd.mul_start = 1'b1;
						state_nx      = S_MUL;
					end
					rsc_pkg::ACT_DIV: begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIV;
					end
					default: begin
						cmd.addsub = 1'b1;
						state_nx   = S_FIN;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_nx    = S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
					state_nx = S_DFIN;
				end
			end
			S_DFIN: begin
				cmd.div_fin = 1'b1;
				state_nx    = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State, divider step count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rsc_datapath.sv
// Datapath of the RPN stack calculator: stack RAM, top register, arithmetic,
// bit-serial divider and output word register. Depends on rsc_pkg and rsc_ram.
`default_nettype none

module rsc_datapath #(
	parameter int STACK_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rsc_pkg::dp_cmd_t                  cmd,
	output rsc_pkg::dp_sts_t                       sts,
	input  wire logic [rsc_pkg::ACT_W-1:0]         in_action,
	input  wire logic signed [rsc_pkg::DATA_W-1:0] in_push_value,
	output logic signed [rsc_pkg::DATA_W-1:0]      top_value,
	output logic                                   top_valid,
	output logic [rsc_pkg::STS_W-1:0]              status,
	output logic [$clog2(STACK_DEPTH + 1)-1:0]     entry_count,
	output logic                                   print_strobe
);

	localparam int DW     = rsc_pkg::DATA_W;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
	localparam logic [63:0] SAT_MAX = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SAT_MIN = 64'hFFFF_FFFF_8000_0000;

	// Token and stack state.
	logic [rsc_pkg::ACT_W-1:0] op_q;
	logic [DW-1:0]             pv_q;
	logic                      ok_q;
	logic [rsc_pkg::STS_W-1:0] st_q;
	logic [CNT_W-1:0]          sp_q;
	logic [DW-1:0]             top_q;
	logic [DW-1:0]             res_q;

	// Arithmetic state.
	logic signed [63:0] prod_s1;
	logic [DW-1:0]      rem_q;
	logic [32:0]        lo_q;
	logic [DW-1:0]      dvs_q;
	logic [32:0]        quo_q;
	logic               neg_q;
	logic               ovf_q;

	// Output word register.
	logic [DW-1:0]             o_value_q;
	logic                      o_valid_q;
	logic [rsc_pkg::STS_W-1:0] o_status_q;
	logic [CNT_W-1:0]          o_count_q;
	logic                      o_strobe_q;

	// Stack RAM holds the entries below the top.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DW-1:0]     rd_word;

	// Capture decode.
	logic                      sp_lt2;
	logic                      sp_zero;
	logic                      sp_full;
	logic                      cap_ok;
	logic [rsc_pkg::STS_W-1:0] cap_st;

	// Combinational arithmetic.
	logic [32:0]   sum33;
	logic [63:0]   sum64;
	logic [63:0]   mul_sh;
	logic [63:0]   mul_v;
	logic [63:0]   sat_in;
	logic [DW-1:0] sat_val;
	logic          sat_hit;
	logic [DW-1:0] abs_l;
	logic [DW-1:0] abs_r;
	logic [63:0]   dvd;
	logic [32:0]   trial;
	logic          trial_ge;
	logic          dq_sat;
	logic [DW-1:0] dq_val;

	// Commit next values.
	logic [CNT_W-1:0] nx_sp;
	logic [DW-1:0]    nx_top;

	assign sp_zero = (sp_q == '0);
	assign sp_lt2  = (sp_q < CNT_W'(2));
	assign sp_full = (sp_q >= CNT_W'(STACK_DEPTH));

	// Classify the incoming token against the current stack.
	always_comb begin
		cap_ok = 1'b0;
		cap_st = rsc_pkg::ST_OK;
		case (in_action) inside
			rsc_pkg::ACT_PUSH: begin
				cap_ok = !sp_full;
				cap_st = sp_full ? rsc_pkg::ST_FULL : rsc_pkg::ST_OK;
			end
			rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL: begin
				cap_ok = !sp_lt2;
				cap_st = sp_lt2 ? rsc_pkg::ST_UNDERFLOW : rsc_pkg::ST_OK;
			end
			rsc_pkg::ACT_DIV: begin
				if (sp_lt2) begin
					cap_st = rsc_pkg::ST_UNDERFLOW;
				end else if (top_q == '0) begin
					cap_st = rsc_pkg::ST_DIVZERO;
				end else begin
					cap_ok = 1'b1;
				end
			end
			rsc_pkg::ACT_PRINT: begin
				cap_st = sp_zero ? rsc_pkg::ST_UNDERFLOW : rsc_pkg::ST_OK;
			end
			rsc_pkg::ACT_CLEAR: begin
				cap_ok = 1'b1;
			end
			default: begin
				cap_ok = 1'b0;
			end
		endcase
	end

	// An operator with enough operands needs the entry below the top.
	assign sts.op_go = cap_ok && (in_action != rsc_pkg::ACT_PUSH)
		&& (in_action != rsc_pkg::ACT_CLEAR);
	assign sts.op    = op_q;

	// Add or subtract with one guard bit; the top is the right operand.
	always_comb begin
		if (op_q == rsc_pkg::ACT_SUB) begin
			sum33 = {rd_word[DW-1], rd_word} - {top_q[DW-1], top_q};
		end else begin
			sum33 = {rd_word[DW-1], rd_word} + {top_q[DW-1], top_q};
		end
		sum64 = {{31{sum33[32]}}, sum33};
	end

	// Product scaled down by the fraction bits, truncated toward zero.
	assign mul_sh = 64'(prod_s1 >>> FRAC_BITS);
	assign mul_v  = mul_sh + {63'd0, prod_s1[63] && ((prod_s1 & FRAC_MASK) != '0)};

	// Saturation to the 32-bit signed range.
	assign sat_in = cmd.mul_fin ? mul_v : sum64;
	always_comb begin
		sat_hit = 1'b0;
		sat_val = sat_in[DW-1:0];
		if (!sat_in[63] && (sat_in > SAT_MAX)) begin
			sat_hit = 1'b1;
			sat_val = SAT_MAX[DW-1:0];
		end else if (sat_in[63] && (sat_in < SAT_MIN)) begin
			sat_hit = 1'b1;
			sat_val = SAT_MIN[DW-1:0];
		end
	end

	// Divider set-up: magnitudes and the scaled dividend.
	assign abs_l = rd_word[DW-1] ? (~rd_word + 1'b1) : rd_word;
	assign abs_r = top_q[DW-1] ? (~top_q + 1'b1) : top_q;
	assign dvd   = {32'd0, abs_l} << FRAC_BITS;

	// One restoring division step.
	assign trial    = {rem_q, lo_q[32]};
	assign trial_ge = (trial >= {1'b0, dvs_q});

	// Signed, saturated quotient.
	always_comb begin
		if (neg_q) begin
			dq_sat = ovf_q || (quo_q > 33'h0_8000_0000);
			dq_val = dq_sat ? SAT_MIN[DW-1:0] : DW'(~quo_q + 33'd1);
		end else begin
			dq_sat = ovf_q || (quo_q > 33'h0_7FFF_FFFF);
			dq_val = dq_sat ? SAT_MAX[DW-1:0] : quo_q[DW-1:0];
		end
	end

	// Stack after the token.
	always_comb begin
		nx_sp  = sp_q;
		nx_top = top_q;
		if (ok_q) begin
			case (op_q) inside
				rsc_pkg::ACT_PUSH: begin
					nx_sp  = sp_q + 1'b1;
					nx_top = pv_q;
				end
				rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL, rsc_pkg::ACT_DIV: begin
					nx_sp  = sp_q - 1'b1;
					nx_top = res_q;
				end
				rsc_pkg::ACT_CLEAR: begin
					nx_sp = '0;
				end
				default: begin
					nx_sp = sp_q;
				end
			endcase
		end
	end

	// A push moves the old top down into the RAM.
	assign ram_we    = cmd.commit && ok_q && (op_q == rsc_pkg::ACT_PUSH) && !sp_zero;
	assign ram_waddr = ADDR_W'(sp_q - 1'b1);
	assign ram_raddr = ADDR_W'(sp_q - CNT_W'(2));

	rsc_ram #(
		.WIDTH(DW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(top_q),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(rd_word)
	);

	// Stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.commit) begin
			sp_q <= nx_sp;
		end
	end

	// Token capture, top register and arithmetic results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_action;
			pv_q <= in_push_value;
			ok_q <= cap_ok;
			st_q <= cap_st;
		end
		if (cmd.commit) begin
			top_q <= nx_top;
		end
		if (cmd.addsub || cmd.mul_fin) begin
			res_q <= sat_val;
			if (sat_hit) begin
				st_q <= rsc_pkg::ST_SAT;
			end
		end
		if (cmd.div_fin) begin
			res_q <= dq_val;
			if (dq_sat) begin
				st_q <= rsc_pkg::ST_SAT;
			end
		end
		if (cmd.mul_start) begin
			prod_s1 <= 64'($signed(rd_word)) * 64'($signed(top_q));
		end
		if (cmd.div_start) begin
			neg_q <= rd_word[DW-1] ^ top_q[DW-1];
			dvs_q <= abs_r;
			ovf_q <= ({1'b0, dvd[63:33]} >= abs_r);
			rem_q <= {1'b0, dvd[63:33]};
			lo_q  <= dvd[32:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			lo_q  <= {lo_q[31:0], 1'b0};
			quo_q <= {quo_q[31:0], trial_ge};
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_value_q  <= (nx_sp != '0) ? nx_top : '0;
			o_valid_q  <= (nx_sp != '0);
			o_status_q <= st_q;
			o_count_q  <= nx_sp;
			o_strobe_q <= (op_q == rsc_pkg::ACT_PRINT);
		end
	end

	assign top_value    = o_value_q;
	assign top_valid    = o_valid_q;
	assign status       = o_status_q;
	assign entry_count  = o_count_q;
	assign print_strobe = o_strobe_q;

endmodule

`default_nettype wire

// File: rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: controller plus datapath.
// Depends on rsc_pkg, rsc_token_if, rsc_result_if, rsc_ctrl and rsc_datapath.
//
//   Channel  Direction  Word carries
//   token    in         action, push_value
//   result   out        top_value, top_valid, status, entry_count, print_strobe
//
// One token is handled at a time. Push, print, clear, no-op and error tokens go
// from capture to commit; operators first read the stack RAM, then multiply forms
// a product and the bit-serial divider makes one quotient bit per cycle over 33 bits.
// A finished word waits in the output register while the next token is taken.
// Reset empties the stack at once; no clearing pass is needed.
`default_nettype none

module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rsc_token_if.sink   token,
	rsc_result_if.source result
);

	rsc_pkg::dp_cmd_t cmd;
	rsc_pkg::dp_sts_t sts;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (token.valid),
		.in_ready (token.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsc_datapath #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (token.action),
		.in_push_value(token.push_value),
		.top_value    (result.top_value),
		.top_valid    (result.top_valid),
		.status       (result.status),
		.entry_count  (result.entry_count),
		.print_strobe (result.print_strobe)
	);

endmodule

`default_nettype wire
